// ===== rtl/circle_pair_collision_filter_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef CIRCLE_PAIR_COLLISION_FILTER_DEFINES_SVH
`define CIRCLE_PAIR_COLLISION_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CPCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpcf: implication check failed");
`define CPCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpcf: next-cycle check failed");
`else
`define CPCF_ASSERT_IMP(lbl, ante, cons)
`define CPCF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/cpcf_pkg.sv =====
`default_nettype none
package cpcf_pkg;

  localparam int RESULT_LIMIT = 31;
  localparam int INDEX_W      = 5;

  typedef struct packed {
    logic               start_frame;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        radius;
    logic [15:0]        category_bits;
    logic [15:0]        hit_mask;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] earlier_index;
    logic [INDEX_W-1:0] current_index;
    logic               last_pair;
  } out_item_t;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [15:0] r;
    logic [15:0] cat;
    logic [15:0] mask;
  } circle_t;

  localparam int CIRCLE_W = $bits(circle_t);

  typedef struct packed {
    logic busy;
    logic pend_valid;
  } back_stat_t;

endpackage
`default_nettype wire

// ===== rtl/circle_pair_collision_filter.sv =====
// Circle pair collision filter.
// Input channel: a queue interface. Drive in_item and raise in_push; the collider
// transfers on a clock edge with in_push high and in_full low. start_frame set
// forgets all colliders stored so far before the new one is handled.
// Result channel: a queue interface. While out_empty is low, out_item holds the
// oldest colliding pair (earlier index, current index, last_pair on the final
// pair of that collider); it transfers on an edge with out_pop high.
// A front stage assigns frame indices and drops colliders past MAX_COLLIDERS;
// a two-entry command queue feeds the scan engine, which reads one stored
// collider per cycle, unless the result queue is full, from the collider RAM
// through a three-stage compare pipe. A collider's scan runs through command
// pop, one RAM read per earlier collider, the three compare stages and the
// store write; the engine takes the next command only after that write.
// The front accepts new colliders while the command queue has room.
// Reset (synchronous, rst_n low) empties both queues and clears the frame
// count; the RAM needs no clearing. When the receiver stops popping, the
// two-entry result queue fills, the scan engine freezes, and the command
// queue then backs up to in_full.
`default_nettype none
`include "circle_pair_collision_filter_defines.svh"
module circle_pair_collision_filter #(
  parameter int MAX_COLLIDERS = 32,
  parameter int MASK_BITS     = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire cpcf_pkg::in_item_t   in_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output cpcf_pkg::out_item_t       out_item
);
  import cpcf_pkg::*;

  localparam int IW    = $clog2(MAX_COLLIDERS);
  localparam int CMD_W = CIRCLE_W + IW;
  localparam int RES_W = $bits(out_item_t);

  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0]   cmd_wdata, cmd_rdata;
  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [CIRCLE_W-1:0] ram_wdata, ram_rdata;
  logic               res_push, res_full;
  out_item_t          res_data;
  logic [RES_W-1:0]   res_rdata;
  back_stat_t         stat;

  assign in_full = cmd_full;

  cpcf_front #(
    .MAX_COLLIDERS (MAX_COLLIDERS),
    .MASK_BITS     (MASK_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata)
  );

  cpcf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wdata),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  cpcf_ram #(
    .WIDTH (CIRCLE_W),
    .DEPTH (MAX_COLLIDERS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpcf_back #(
    .MAX_COLLIDERS (MAX_COLLIDERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .stat      (stat)
  );

  cpcf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rdata),
    .empty   (out_empty)
  );

  assign out_item = out_item_t'(res_rdata);

  `CPCF_ASSERT_IMP(a_pend_only_busy, stat.pend_valid, stat.busy)
  `CPCF_ASSERT_IMP(a_res_no_overflow, res_push, !res_full)
  `CPCF_ASSERT_IMP(a_cmd_no_overflow, cmd_push, !cmd_full)
  `CPCF_ASSERT_NEXT(a_pop_starts_scan, cmd_pop, stat.busy && !stat.pend_valid)

endmodule
`default_nettype wire

// ===== rtl/cpcf_ram.sv =====
`default_nettype none
module cpcf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/cpcf_fifo.sv =====
`default_nettype none
module cpcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpcf_front.sv =====
`default_nettype none
module cpcf_front #(
  parameter int MAX_COLLIDERS = 32,
  parameter int MASK_BITS     = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         in_push,
  input  wire cpcf_pkg::in_item_t                           in_item,
  input  wire logic                                         cmd_full,
  output logic                                              cmd_push,
  output logic [cpcf_pkg::CIRCLE_W+$clog2(MAX_COLLIDERS)-1:0] cmd_data
);
  import cpcf_pkg::*;

  localparam int IW = $clog2(MAX_COLLIDERS);
  localparam int CW = $clog2(MAX_COLLIDERS + 1);
  localparam logic [15:0] GROUP_MASK =
    (MASK_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << MASK_BITS) - 32'd1);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] base;
  logic          accept, drop;
  circle_t       circ;

  assign accept = in_push && !cmd_full;
  assign base   = in_item.start_frame ? '0 : count_r;
  assign drop   = (base >= CW'(MAX_COLLIDERS));

  always_comb begin
    circ.x    = in_item.pos_x;
    circ.y    = in_item.pos_y;
    circ.r    = in_item.radius;
    circ.cat  = in_item.category_bits & GROUP_MASK;
    circ.mask = in_item.hit_mask & GROUP_MASK;
  end

  assign cmd_push = accept && !drop;
  assign cmd_data = {IW'(base), circ};

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = drop ? base : base + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cpcf_back.sv =====
`default_nettype none
module cpcf_back #(
  parameter int MAX_COLLIDERS = 32
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             cmd_empty,
  input  wire logic [cpcf_pkg::CIRCLE_W+$clog2(MAX_COLLIDERS)-1:0] cmd_data,
  output logic                                                  cmd_pop,
  output logic                                                  ram_we,
  output logic [$clog2(MAX_COLLIDERS)-1:0]                      ram_waddr,
  output logic [cpcf_pkg::CIRCLE_W-1:0]                         ram_wdata,
  output logic                                                  ram_re,
  output logic [$clog2(MAX_COLLIDERS)-1:0]                      ram_raddr,
  input  wire logic [cpcf_pkg::CIRCLE_W-1:0]                    ram_rdata,
  input  wire logic                                             res_full,
  output logic                                                  res_push,
  output cpcf_pkg::out_item_t                                   res_data,
  output cpcf_pkg::back_stat_t                                  stat
);
  import cpcf_pkg::*;

  localparam int IW = $clog2(MAX_COLLIDERS);

  // control
  logic                busy_r, busy_nxt;
  logic [IW-1:0]       cur_idx_r;
  circle_t             cur_r;
  logic [IW-1:0]       addr_r, addr_nxt;
  logic                v1_r, v2_r, v3_r;
  logic [INDEX_W-1:0]  e1_r, e2_r, e3_r;
  logic                pend_v_r, pend_v_nxt;
  logic [INDEX_W-1:0]  pend_e_r;
  logic [INDEX_W-1:0]  taken_r, taken_nxt;

  // datapath
  logic signed [24:0]  dx2_s, dy2_s;
  logic [16:0]         rs2_s;
  logic                match2_r;
  logic signed [24:0]  dx_r, dy_r;
  logic [16:0]         rs_r;
  logic                match3_r;
  logic [49:0]         dxsq_r, dysq_r;
  logic [33:0]         rssq_r;
  logic signed [49:0]  dxsq_p, dysq_p;

  circle_t             stored;
  logic                adv, issuing, pipe_empty, finish, hit3, take;
  logic [50:0]         d2;

  assign stored     = circle_t'(ram_rdata);
  assign adv        = !res_full;
  assign issuing    = busy_r && (addr_r < cur_idx_r);
  assign pipe_empty = !v1_r && !v2_r && !v3_r;
  assign finish     = adv && busy_r && !issuing && pipe_empty;
  assign cmd_pop    = adv && !busy_r && !cmd_empty;

  assign ram_re    = adv;
  assign ram_raddr = addr_r;
  assign ram_we    = finish;
  assign ram_waddr = cur_idx_r;
  assign ram_wdata = cur_r;

  // difference, radius sum and group filter on the freshly read entry
  assign dx2_s  = $signed({stored.x[23], stored.x}) - $signed({cur_r.x[23], cur_r.x});
  assign dy2_s  = $signed({stored.y[23], stored.y}) - $signed({cur_r.y[23], cur_r.y});
  assign rs2_s  = {1'b0, stored.r} + {1'b0, cur_r.r};

  assign dxsq_p = 50'(dx_r) * 50'(dx_r);
  assign dysq_p = 50'(dy_r) * 50'(dy_r);

  assign d2   = {1'b0, dxsq_r} + {1'b0, dysq_r};
  assign hit3 = v3_r && match3_r && (d2 <= {17'd0, rssq_r});
  assign take = hit3 && (taken_r != INDEX_W'(RESULT_LIMIT));

  assign res_push = adv && pend_v_r && (take || finish);
  always_comb begin
    res_data.earlier_index = pend_e_r;
    res_data.current_index = INDEX_W'(cur_idx_r);
    res_data.last_pair     = finish;
  end

  assign stat.busy       = busy_r;
  assign stat.pend_valid = pend_v_r;

  always_comb begin
    busy_nxt   = busy_r;
    addr_nxt   = addr_r;
    pend_v_nxt = pend_v_r;
    taken_nxt  = taken_r;
    if (cmd_pop) begin
      busy_nxt   = 1'b1;
      addr_nxt   = '0;
      pend_v_nxt = 1'b0;
      taken_nxt  = '0;
    end else if (adv) begin
      if (issuing) begin
        addr_nxt = addr_r + IW'(1);
      end
      // a new hit pushes out the held one; the held one is last only at finish
      if (take) begin
        pend_v_nxt = 1'b1;
        taken_nxt  = taken_r + INDEX_W'(1);
      end
      if (finish) begin
        busy_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      addr_r   <= '0;
      pend_v_r <= 1'b0;
      taken_r  <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      addr_r   <= addr_nxt;
      pend_v_r <= pend_v_nxt;
      taken_r  <= taken_nxt;
      if (adv) begin
        v1_r <= issuing;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_idx_r <= cmd_data[CIRCLE_W +: IW];
      cur_r     <= circle_t'(cmd_data[CIRCLE_W-1:0]);
    end
    if (adv) begin
      e1_r     <= INDEX_W'(addr_r);
      e2_r     <= e1_r;
      dx_r     <= dx2_s;
      dy_r     <= dy2_s;
      rs_r     <= rs2_s;
      match2_r <= |((stored.mask & cur_r.cat) | (cur_r.mask & stored.cat));
      e3_r     <= e2_r;
      match3_r <= match2_r;
      dxsq_r   <= 50'(dxsq_p);
      dysq_r   <= 50'(dysq_p);
      rssq_r   <= 34'(rs_r) * 34'(rs_r);
      if (take) begin
        pend_e_r <= e3_r;
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_circle_pair_collision_filter.sv =====
`timescale 1ns / 100ps

module tb_circle_pair_collision_filter;
  import cpcf_pkg::*;

  localparam int MAX_COLLIDERS = 32;
  localparam int MASK_BITS = 16;
  localparam logic [15:0] GROUP_MASK = 16'((32'd1 << MASK_BITS) - 1);

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  in_item_t in_item;
  logic out_empty;
  logic out_pop;
  out_item_t out_item;

  circle_pair_collision_filter #(
    .MAX_COLLIDERS(MAX_COLLIDERS),
    .MASK_BITS(MASK_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_item(in_item),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_item(out_item)
  );

  // Colliders stored in the current frame, as the block should hold them
  longint frame_x[MAX_COLLIDERS];
  longint frame_y[MAX_COLLIDERS];
  logic [15:0] frame_r[MAX_COLLIDERS];
  logic [15:0] frame_cat[MAX_COLLIDERS];
  logic [15:0] frame_mask[MAX_COLLIDERS];
  int frame_count = 0;

  out_item_t expected_pairs[$];
  int pair_errors = 0;

  bit push_high = 1'b0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int rx_hold = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** circle_pair_collision_filter: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Work out the pairs the accepted collider must produce, then store it
  function automatic void predict_pairs(input in_item_t it);
    longint px, py, dx, dy, rs;
    logic [15:0] cat, hmask;
    int hits[$];
    out_item_t p;
    if (it.start_frame) frame_count = 0;
    if (frame_count >= MAX_COLLIDERS) return;
    px = longint'($signed(it.pos_x));
    py = longint'($signed(it.pos_y));
    cat = it.category_bits & GROUP_MASK;
    hmask = it.hit_mask & GROUP_MASK;
    for (int i = 0; i < frame_count; i++) begin
      if (((frame_mask[i] & cat) | (hmask & frame_cat[i])) == '0) continue;
      dx = frame_x[i] - px;
      dy = frame_y[i] - py;
      rs = longint'(frame_r[i]) + longint'(it.radius);
      if (dx * dx + dy * dy > rs * rs) continue;
      if (hits.size() < RESULT_LIMIT) hits = {hits, i};
    end
    foreach (hits[k]) begin
      p.earlier_index = INDEX_W'(hits[k]);
      p.current_index = INDEX_W'(frame_count);
      p.last_pair = (k == hits.size() - 1);
      expected_pairs = {expected_pairs, p};
    end
    frame_x[frame_count] = px;
    frame_y[frame_count] = py;
    frame_r[frame_count] = it.radius;
    frame_cat[frame_count] = cat;
    frame_mask[frame_count] = hmask;
    frame_count++;
  endfunction

  function automatic void check_pair(input out_item_t got);
    out_item_t want;
    if (expected_pairs.size() == 0) begin
      pair_errors++;
      if (pair_errors <= 10)
        $display("%0t: unexpected pair earlier=%0d current=%0d last=%0b", $realtime,
                 got.earlier_index, got.current_index, got.last_pair);
      return;
    end
    want = expected_pairs.pop_front();
    if (got.earlier_index !== want.earlier_index || got.current_index !== want.current_index ||
        got.last_pair !== want.last_pair) begin
      pair_errors++;
      if (pair_errors <= 10)
        $display("%0t: pair mismatch: expected %0d/%0d last=%0b, got %0d/%0d last=%0b",
                 $realtime, want.earlier_index, want.current_index, want.last_pair,
                 got.earlier_index, got.current_index, got.last_pair);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_pair(out_item);
  end

  // Receiver: random stalls, plus a long hold when the pressure test asks
  initial begin
    int g;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        g = rx_hold;
        rx_hold = 0;
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        g = pick_gap();
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t collider(bit sf, int x, int y, int r, int cat, int msk);
    in_item_t it;
    it.start_frame = sf;
    it.pos_x = 24'(x);
    it.pos_y = 24'(y);
    it.radius = 16'(r);
    it.category_bits = 16'(cat);
    it.hit_mask = 16'(msk);
    return it;
  endfunction

  function automatic in_item_t noise_collider();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return in_item_t'(raw[$bits(in_item_t)-1:0]);
  endfunction

  // Collider near a frame center so that pairs actually overlap
  function automatic in_item_t cluster_collider(bit sf, int cx, int cy);
    in_item_t it;
    it.start_frame = sf;
    it.pos_x = 24'(cx + int'($urandom_range(0, 2048)) - 1024);
    it.pos_y = 24'(cy + int'($urandom_range(0, 2048)) - 1024);
    it.radius = ($urandom_range(0, 6) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1024));
    it.category_bits = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                   : 16'(1 << $urandom_range(0, 3));
    it.hit_mask = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 15));
    return it;
  endfunction

  // Offer one collider until it transfers; push stays high if no gap follows
  task automatic send_collider(input in_item_t it);
    int g;
    in_item <= it;
    in_push <= 1'b1;
    push_high = 1'b1;
    do @(posedge clk); while (in_full);
    predict_pairs(it);
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      g = pick_gap();
      in_push <= 1'b0;
      push_high = 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic release_input();
    if (push_high) begin
      in_push <= 1'b0;
      push_high = 1'b0;
    end
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_collider(collider(1, 0, 0, 0, 1, 1));
    // zero-radius circles on the same center touch
    send_collider(collider(0, 0, 0, 0, 1, 1));
    send_collider(collider(0, 48, 64, 79, 1, 1));
    // distance equals radius sum: touching counts
    send_collider(collider(0, 48, 64, 80, 1, 1));
    send_collider(collider(0, 0, 0, 5, 2, 0));
    // only one direction of the mask test matches
    send_collider(collider(0, 0, 0, 5, 4, 2));
    send_collider(collider(0, 0, 0, 65535, 0, 0));
    send_collider(collider(1, -8388608, -8388608, 65535, 16'hFFFF, 16'hFFFF));
    send_collider(collider(0, 8388607, 8388607, 65535, 16'hFFFF, 16'hFFFF));
    send_collider(collider(0, -8388608, 8388607, 65535, 16'hFFFF, 16'hFFFF));
    send_collider(collider(0, 8388607, -8388608, 65535, 16'hFFFF, 16'hFFFF));
    send_collider(collider(0, -8388508, -8388608, 0, 16'h8000, 16'h8000));
    send_collider(collider(0, 0, 0, 0, 16'h0001, 16'h8000));
    send_collider(collider(1, 100, -100, 16, 1, 1));
    send_collider(collider(1, 100, -100, 16, 1, 1));
    send_collider(collider(0, 101, -100, 0, 1, 1));
  endtask

  // Fill the frame past capacity, then restart it from the full state
  task automatic test_store_overflow();
    int cx, cy;
    cx = int'($urandom_range(0, 16000000)) - 8000000;
    cy = int'($urandom_range(0, 16000000)) - 8000000;
    for (int k = 0; k < MAX_COLLIDERS + 3; k++) send_collider(cluster_collider(k == 0, cx, cy));
    send_collider(cluster_collider(1, cx, cy));
    send_collider(cluster_collider(0, cx, cy));
  endtask

  // Hold the receiver off while every collider overlaps every other one
  task automatic test_output_stall();
    wait_drained();
    tx_idle_on = 1'b0;
    rx_hold = 600;
    for (int k = 0; k < 24; k++)
      send_collider(collider(k == 0, 4000 + k, -3000 - k, 256, 16'hFFFF, 16'hFFFF));
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_frames(input int n_items);
    int left, len, cx, cy, pick;
    left = n_items;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(2, 12);
      else if (pick < 92) len = $urandom_range(13, 28);
      else len = $urandom_range(30, 36);
      cx = int'($urandom_range(0, 16000000)) - 8000000;
      cy = int'($urandom_range(0, 16000000)) - 8000000;
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < len && left > 0; k++) begin
        if ($urandom_range(0, 9) == 0) send_collider(noise_collider());
        else send_collider(cluster_collider(k == 0, cx, cy));
        left--;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_store_overflow();
    test_output_stall();
    test_random_frames(220);

    wait_drained();
    repeat (100) @(posedge clk);
    if (pair_errors == 0 && expected_pairs.size() == 0)
      $display("** circle_pair_collision_filter: PASSED **");
    else
      $display("** circle_pair_collision_filter: FAILED **");
    $finish;
  end

endmodule
